/* src/paes_pkg.sv */
// Shared types and codes of the print abort escalation sequencer.
`default_nettype none
package paes_pkg;

  localparam int CntW = 24;
  localparam int CmdCntW = 16;
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // Event codes
  localparam logic [3:0] ACT_TICK          = 4'd0;
  localparam logic [3:0] ACT_START         = 4'd1;
  localparam logic [3:0] ACT_HEAT_OK       = 4'd2;
  localparam logic [3:0] ACT_HEAT_ERR      = 4'd3;
  localparam logic [3:0] ACT_PROBE_OK      = 4'd4;
  localparam logic [3:0] ACT_PROBE_ERR     = 4'd5;
  localparam logic [3:0] ACT_CANCEL_OK     = 4'd6;
  localparam logic [3:0] ACT_CANCEL_ERR    = 4'd7;
  localparam logic [3:0] ACT_ESTOP_DONE    = 4'd8;
  localparam logic [3:0] ACT_RESTART_DONE  = 4'd9;
  localparam logic [3:0] ACT_CTRL_STATE    = 4'd10;
  localparam logic [3:0] ACT_PRINT_STATE   = 4'd11;

  // Controller states
  localparam logic [1:0] CTRL_READY    = 2'd0;
  localparam logic [1:0] CTRL_SHUTDOWN = 2'd2;

  // Job states that end the print
  localparam logic [2:0] JOB_STANDBY   = 3'd0;
  localparam logic [2:0] JOB_COMPLETE  = 3'd3;
  localparam logic [2:0] JOB_CANCELLED = 3'd4;
  localparam logic [2:0] JOB_ERROR     = 3'd5;

  // Soft interrupt capability
  localparam logic [1:0] CAP_UNKNOWN  = 2'd0;
  localparam logic [1:0] CAP_DETECTED = 2'd1;
  localparam logic [1:0] CAP_ABSENT   = 2'd2;

  // Commands
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_SOFT_INT = 3'd1;
  localparam logic [2:0] CMD_PROBE    = 3'd2;
  localparam logic [2:0] CMD_CANCEL   = 3'd3;
  localparam logic [2:0] CMD_ESTOP    = 3'd4;
  localparam logic [2:0] CMD_RESTART  = 3'd5;

  // Messages
  localparam logic [2:0] MSG_EMPTY      = 3'd0;
  localparam logic [2:0] MSG_STOPPING   = 3'd1;
  localparam logic [2:0] MSG_EMERGENCY  = 3'd2;
  localparam logic [2:0] MSG_RESTARTING = 3'd3;
  localparam logic [2:0] MSG_CANCELLED  = 3'd4;
  localparam logic [2:0] MSG_ABORT_HOME = 3'd5;
  localparam logic [2:0] MSG_RECONNECT  = 3'd6;

  // Register indexes
  localparam logic [2:0] REG_HEATER_TO    = 3'd0;
  localparam logic [2:0] REG_PROBE_TO     = 3'd1;
  localparam logic [2:0] REG_CANCEL_EN    = 3'd2;
  localparam logic [2:0] REG_CANCEL_TO    = 3'd3;
  localparam logic [2:0] REG_RECONNECT_TO = 3'd4;

  typedef struct packed {
    logic [3:0] action;
    logic [1:0] controller_state;
    logic [2:0] job_state;
  } req_t;

  typedef struct packed {
    logic [2:0]         phase;
    logic [1:0]         capability;
    logic [2:0]         command_out;
    logic [2:0]         message_code;
    logic               escalated;
    logic [CmdCntW-1:0] commands_total;
    logic               recovery_active;
    logic               aborting;
    logic               outcome_cancelled;
  } rsp_t;

  typedef struct packed {
    logic [CntW-1:0] heater_timeout_ticks;
    logic [CntW-1:0] probe_timeout_ticks;
    logic            cancel_escalate_enable;
    logic [CntW-1:0] cancel_timeout_ticks;
    logic [CntW-1:0] reconnect_timeout_ticks;
  } cfg_t;

endpackage
`default_nettype wire

/* src/paes_cfg.sv */
// Configuration register file behind the APB-style port.
`default_nettype none
module paes_cfg import paes_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heater_timeout_ticks    <= CntW'(1000);
      cfg.probe_timeout_ticks     <= CntW'(5000);
      cfg.cancel_escalate_enable  <= 1'b1;
      cfg.cancel_timeout_ticks    <= CntW'(30000);
      cfg.reconnect_timeout_ticks <= CntW'(60000);
    end else if (wr) begin
      unique case (idx)
        REG_HEATER_TO:    cfg.heater_timeout_ticks    <= pwdata[CntW-1:0];
        REG_PROBE_TO:     cfg.probe_timeout_ticks     <= pwdata[CntW-1:0];
        REG_CANCEL_EN:    cfg.cancel_escalate_enable  <= pwdata[0];
        REG_CANCEL_TO:    cfg.cancel_timeout_ticks    <= pwdata[CntW-1:0];
        REG_RECONNECT_TO: cfg.reconnect_timeout_ticks <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HEATER_TO:    prdata = DataW'(cfg.heater_timeout_ticks);
      REG_PROBE_TO:     prdata = DataW'(cfg.probe_timeout_ticks);
      REG_CANCEL_EN:    prdata = DataW'(cfg.cancel_escalate_enable);
      REG_CANCEL_TO:    prdata = DataW'(cfg.cancel_timeout_ticks);
      REG_RECONNECT_TO: prdata = DataW'(cfg.reconnect_timeout_ticks);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* src/paes_core.sv */
// Abort phase state, timeout timer and command counter with next-state logic.
`default_nettype none
module paes_core import paes_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire req_t req,
  input  wire cfg_t cfg,
  output rsp_t      rsp
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SOFT_INT  = 3'd1,
    PH_PROBE     = 3'd2,
    PH_CANCEL    = 3'd3,
    PH_ESTOP     = 3'd4,
    PH_RESTART   = 3'd5,
    PH_WAIT      = 3'd6,
    PH_COMPLETE  = 3'd7
  } phase_t;

  localparam logic [CntW-1:0]    CntMax = '1;
  localparam logic [CmdCntW-1:0] CmdMax = '1;

  phase_t             phase, phase_next;
  logic [1:0]         capability, capability_next;
  logic [CntW-1:0]    timeout_count, timeout_count_next;
  logic               timer_armed, timer_armed_next;
  logic               seen_shutdown, seen_shutdown_next;
  logic               recovery_flag, recovery_flag_next;
  logic               escalation, escalation_next;
  logic [CmdCntW-1:0] command_count, command_count_next;
  logic [2:0]         message, message_next;

  logic            busy;
  logic [CntW-1:0] cnt_inc;
  logic [CntW-1:0] limit;
  logic            go_probe, go_cancel, go_esc, go_fin;
  logic [2:0]      fin_msg;
  logic [2:0]      cmd;

  always_comb begin
    phase_next         = phase;
    capability_next    = capability;
    timeout_count_next = timeout_count;
    timer_armed_next   = timer_armed;
    seen_shutdown_next = seen_shutdown;
    recovery_flag_next = recovery_flag;
    escalation_next    = escalation;
    message_next       = message;
    cmd                = CMD_NONE;
    go_probe           = 1'b0;
    go_cancel          = 1'b0;
    go_esc             = 1'b0;
    go_fin             = 1'b0;
    fin_msg            = MSG_EMPTY;

    busy    = (phase != PH_IDLE) && (phase != PH_COMPLETE);
    cnt_inc = (timeout_count != CntMax) ? timeout_count + 1'b1 : timeout_count;

    unique case (phase)
      PH_SOFT_INT: limit = cfg.heater_timeout_ticks;
      PH_PROBE:    limit = cfg.probe_timeout_ticks;
      PH_CANCEL:   limit = cfg.cancel_timeout_ticks;
      default:     limit = cfg.reconnect_timeout_ticks;
    endcase

    unique case (req.action)
      ACT_TICK: begin
        if (timer_armed) begin
          if (phase == PH_SOFT_INT || phase == PH_PROBE || phase == PH_CANCEL ||
              phase == PH_WAIT) begin
            timeout_count_next = cnt_inc;
            if (cnt_inc >= limit) begin
              unique case (phase)
                PH_SOFT_INT: begin
                  capability_next = CAP_ABSENT;
                  go_probe        = 1'b1;
                end
                PH_WAIT: begin
                  go_fin  = 1'b1;
                  fin_msg = MSG_RECONNECT;
                end
                default: go_esc = 1'b1;
              endcase
            end
          end else begin
            timer_armed_next = 1'b0;
          end
        end
      end
      ACT_START: begin
        if (!busy) begin
          escalation_next = 1'b0;
          message_next    = MSG_STOPPING;
          if (capability == CAP_ABSENT) begin
            go_probe = 1'b1;
          end else begin
            phase_next         = PH_SOFT_INT;
            timer_armed_next   = 1'b1;
            timeout_count_next = '0;
            cmd                = CMD_SOFT_INT;
          end
        end
      end
      ACT_HEAT_OK, ACT_HEAT_ERR: begin
        if (phase == PH_SOFT_INT) begin
          capability_next = (req.action == ACT_HEAT_OK) ? CAP_DETECTED : CAP_ABSENT;
          go_probe        = 1'b1;
        end
      end
      ACT_PROBE_OK:   go_cancel = (phase == PH_PROBE);
      ACT_PROBE_ERR:  go_esc    = (phase == PH_PROBE);
      ACT_CANCEL_OK: begin
        go_fin  = (phase == PH_CANCEL);
        fin_msg = MSG_CANCELLED;
      end
      ACT_CANCEL_ERR: go_esc = (phase == PH_CANCEL);
      ACT_ESTOP_DONE: begin
        if (phase == PH_ESTOP) begin
          phase_next   = PH_RESTART;
          message_next = MSG_RESTARTING;
          cmd          = CMD_RESTART;
        end
      end
      ACT_RESTART_DONE: begin
        if (phase == PH_RESTART) begin
          seen_shutdown_next = 1'b0;
          phase_next         = PH_WAIT;
          message_next       = MSG_RESTARTING;
          timer_armed_next   = 1'b1;
          timeout_count_next = '0;
        end
      end
      ACT_CTRL_STATE: begin
        if (phase == PH_WAIT) begin
          if (req.controller_state == CTRL_SHUTDOWN) begin
            seen_shutdown_next = 1'b1;
          end else if (req.controller_state == CTRL_READY && seen_shutdown) begin
            recovery_flag_next = 1'b0;
            go_fin             = 1'b1;
            fin_msg            = MSG_ABORT_HOME;
          end
        end
      end
      ACT_PRINT_STATE: begin
        go_fin  = (phase == PH_CANCEL) &&
                  (req.job_state == JOB_STANDBY || req.job_state == JOB_COMPLETE ||
                   req.job_state == JOB_CANCELLED || req.job_state == JOB_ERROR);
        fin_msg = MSG_CANCELLED;
      end
      default: ;
    endcase

    if (go_probe) begin
      phase_next         = PH_PROBE;
      message_next       = MSG_STOPPING;
      timer_armed_next   = 1'b1;
      timeout_count_next = '0;
      cmd                = CMD_PROBE;
    end
    if (go_cancel) begin
      phase_next       = PH_CANCEL;
      message_next     = MSG_STOPPING;
      timer_armed_next = cfg.cancel_escalate_enable;
      if (cfg.cancel_escalate_enable) begin
        timeout_count_next = '0;
      end
      cmd = CMD_CANCEL;
    end
    if (go_esc) begin
      escalation_next    = 1'b1;
      recovery_flag_next = 1'b1;
      timer_armed_next   = 1'b0;
      phase_next         = PH_ESTOP;
      message_next       = MSG_EMERGENCY;
      cmd                = CMD_ESTOP;
    end
    if (go_fin) begin
      timer_armed_next = 1'b0;
      phase_next       = PH_COMPLETE;
      message_next     = fin_msg;
    end

    // Count every issued command, holding at the top.
    command_count_next = command_count;
    if (cmd != CMD_NONE && command_count != CmdMax) begin
      command_count_next = command_count + 1'b1;
    end

    rsp.phase             = phase_next;
    rsp.capability        = capability_next;
    rsp.command_out       = cmd;
    rsp.message_code      = message_next;
    rsp.escalated         = escalation_next;
    rsp.commands_total    = command_count_next;
    rsp.recovery_active   = recovery_flag_next;
    rsp.aborting          = (phase_next != PH_IDLE) && (phase_next != PH_COMPLETE);
    rsp.outcome_cancelled = go_fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      capability    <= CAP_UNKNOWN;
      timeout_count <= '0;
      timer_armed   <= 1'b0;
      seen_shutdown <= 1'b0;
      recovery_flag <= 1'b0;
      escalation    <= 1'b0;
      command_count <= '0;
      message       <= MSG_EMPTY;
    end else if (step) begin
      phase         <= phase_next;
      capability    <= capability_next;
      timeout_count <= timeout_count_next;
      timer_armed   <= timer_armed_next;
      seen_shutdown <= seen_shutdown_next;
      recovery_flag <= recovery_flag_next;
      escalation    <= escalation_next;
      command_count <= command_count_next;
      message       <= message_next;
    end
  end

endmodule
`default_nettype wire

/* src/print_abort_escalation_sequencer_unit.sv */
// Top level of the print abort escalation sequencer: word registers, core and config port.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   req     | in        | req_valid / req_ready  | req_data  (paes_pkg::req_t)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_data  (paes_pkg::rsp_t)
//   cfg     | in        | psel/penable/pwrite    | paddr, pwdata, prdata
//
// Each word passes the input register and the next-state logic into the result
// register, where rsp_valid rises once the result slot is free; one word per
// cycle is sustained while rsp_ready stays high.
// rst is synchronous; it clears the sequencer state, both register flags and
// the configuration to its defaults. A stalled rsp holds its word while the
// input register fills; req_ready drops only when both are full.
`default_nettype none
module print_abort_escalation_sequencer_unit import paes_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire req_t             req_data,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output rsp_t                  rsp_data,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  req_t req_q;
  logic req_full;
  rsp_t rsp_next;
  logic advance;

  // Advance the held word into the result register when that slot frees.
  assign advance   = req_full && (!rsp_valid || rsp_ready);
  assign req_ready = !req_full || advance;

  paes_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  paes_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (req_q),
    .cfg  (cfg),
    .rsp  (rsp_next)
  );

  // Input register: load on acceptance, drop once advanced.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req_valid && req_ready) begin
      req_full <= 1'b1;
    end else if (advance) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req_data;
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= rsp_next;
    end
  end

endmodule
`default_nettype wire
